@@ rtl/boundary_tag_fit_allocator_macros.svh @@
// Assertion macros for the boundary-tag fit allocator.
// Included by the top level; uses its i_clk and i_rst_n.
`ifndef BOUNDARY_TAG_FIT_ALLOCATOR_MACROS_SVH
`define BOUNDARY_TAG_FIT_ALLOCATOR_MACROS_SVH
// same-cycle implication
`define BTA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define BTA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ rtl/bta_pkg.sv @@
// Shared types and constants for the boundary-tag fit allocator.
// No dependencies.
package bta_pkg;
    localparam int DEF_REGION_BYTES = 4096;
    localparam int DEF_HEADER_BYTES = 16;
    localparam int OFFSET_LIMIT     = 4096;
    localparam int PW               = 13;   // block position / size width
    localparam int NW               = 14;   // next-position width

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOFIT   = 2'd1;
    localparam logic [1:0] STAT_BADFREE = 2'd2;

    localparam logic       FUNC_ALLOC = 1'b0;
    localparam logic       FUNC_FREE  = 1'b1;

    localparam logic [1:0] REG_FIT_METHOD   = 2'd0;
    localparam logic [1:0] REG_REGION_BYTES = 2'd1;

    typedef struct packed {
        logic          free;
        logic [PW-1:0] size;
    } t_hdr;

    typedef struct packed {
        t_hdr          hdr;
        logic [PW-1:0] pos;
        logic [PW-1:0] req;
        logic [1:0]    method;
        logic          found;
        logic [PW-1:0] pick_size;
        logic [PW-1:0] target;
    } t_eval_in;

    typedef struct packed {
        logic [NW-1:0] next;
        logic          take;
        logic          stop;
        logic          at_target;
        logic          past_target;
    } t_eval_res;
endpackage

@@ rtl/bta_ram.sv @@
// Generic single-port-write, registered-read RAM.
// No dependencies.
module bta_ram #(
    parameter int W     = 14,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/bta_eval.sv @@
// Shared evaluation unit: next-block address, fit test and placement choice.
// Depends on bta_pkg.
module bta_eval #(
    parameter int HEADER_BYTES = bta_pkg::DEF_HEADER_BYTES
) (
    input  bta_pkg::t_eval_in  i_in,
    output bta_pkg::t_eval_res o_res
);
    import bta_pkg::*;

    localparam logic [NW-1:0] HB = NW'(HEADER_BYTES);

    logic fits;
    logic better;

    always_comb begin
        fits = i_in.hdr.free && (i_in.hdr.size >= i_in.req);
        case (i_in.method)
            FIT_BEST:  better = i_in.hdr.size <  i_in.pick_size;
            FIT_WORST: better = i_in.hdr.size >= i_in.pick_size;
            default:   better = 1'b0;
        endcase
        o_res.next        = NW'(i_in.pos) + HB + NW'(i_in.hdr.size);
        o_res.take        = fits && (!i_in.found || better);
        o_res.stop        = fits && (i_in.method != FIT_BEST) && (i_in.method != FIT_WORST);
        o_res.at_target   = i_in.pos == i_in.target;
        o_res.past_target = i_in.pos >  i_in.target;
    end
endmodule

@@ rtl/boundary_tag_fit_allocator.sv @@
// Boundary-tag allocator: each block walked takes a header read, then an evaluate step.
// Throughput: one request at a time; the next is taken in idle, after the o_done strobe,
// so a new request waits for the whole walk. The walk is set by the header RAM's
// single registered read port. Synchronous active-low reset: a header write in ST_INIT
// rebuilds one free block. A result shows on o_done for one cycle; no receiver stall.
`include "boundary_tag_fit_allocator_macros.svh"
module boundary_tag_fit_allocator #(
    parameter int REGION_BYTES = bta_pkg::DEF_REGION_BYTES,
    parameter int HEADER_BYTES = bta_pkg::DEF_HEADER_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request transaction
    input  logic        start,
    output logic        busy,
    input  logic        i_func,
    input  logic [12:0] i_request_size,
    input  logic [11:0] i_free_offset,
    // result transaction
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [11:0] o_data_offset,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [12:0] i_cfg_wdata
);
    import bta_pkg::*;

    // memory only as deep as the addressable part of the region
    localparam int DEPTH = (REGION_BYTES < OFFSET_LIMIT) ? REGION_BYTES : OFFSET_LIMIT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [PW-1:0] HB    = PW'(HEADER_BYTES);
    localparam logic [PW-1:0] DEPTHV = PW'(DEPTH);

    // sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_INIT = 4'd1;  // write the single free block
    localparam logic [3:0] ST_RD   = 4'd2;  // issue header read at r_pos
    localparam logic [3:0] ST_EV   = 4'd3;  // evaluate header
    localparam logic [3:0] ST_NRD  = 4'd4;  // free: read right neighbour
    localparam logic [3:0] ST_NEV  = 4'd5;
    localparam logic [3:0] ST_FW   = 4'd6;  // free: write merged header
    localparam logic [3:0] ST_END  = 4'd7;  // walk finished
    localparam logic [3:0] ST_AW1  = 4'd8;  // alloc: split tail or final header
    localparam logic [3:0] ST_AW2  = 4'd9;  // alloc: shrunk header after split
    localparam logic [3:0] ST_OUT  = 4'd10;

    logic [3:0]    r_state, n_state;
    logic [1:0]    r_method;
    logic [PW-1:0] r_region;
    logic          r_func;
    logic [PW-1:0] r_req;
    logic [PW-1:0] r_target;      // block start named by a free
    logic          r_bad;         // free offset below the header size
    logic [PW-1:0] r_pos, n_pos;
    logic          r_found, n_found;
    logic [PW-1:0] r_pick, n_pick;
    logic [PW-1:0] r_pick_size, n_pick_size;
    logic          r_prev_free, n_prev_free;
    logic [PW-1:0] r_prev, n_prev;
    logic [PW-1:0] r_prev_size, n_prev_size;
    logic [PW-1:0] r_nxt, n_nxt;
    logic          r_next_free, n_next_free;
    logic [PW-1:0] r_next_size, n_next_size;
    logic [1:0]    r_status, n_status;
    logic [11:0]   r_off, n_off;

    logic [PW-1:0] eff;
    logic [PW-1:0] chain_end;
    logic [PW-1:0] split_rem;
    logic          split;
    logic [PW-1:0] split_pos;
    logic [PW-1:0] merge_size;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_hdr          ram_wdata, ram_rdata;

    t_eval_in      ev_in;
    t_eval_res     ev_res;

    // region in use, capped by the memory; too small means an empty chain
    assign eff       = (r_region < DEPTHV) ? r_region : DEPTHV;
    assign chain_end = (eff >= HB) ? eff : '0;

    assign split_rem  = r_pick_size - r_req;
    assign split      = split_rem > HB;
    assign split_pos  = r_pick + HB + r_req;
    assign merge_size = (r_prev_free ? (r_prev_size + HB) : '0) + r_pick_size
                      + (r_next_free ? (HB + r_next_size) : '0);

    bta_ram #(
        .W     ($bits(t_hdr)),
        .DEPTH (DEPTH)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ev_in.hdr       = ram_rdata;
    assign ev_in.pos       = r_pos;
    assign ev_in.req       = r_req;
    assign ev_in.method    = r_method;
    assign ev_in.found     = r_found;
    assign ev_in.pick_size = r_pick_size;
    assign ev_in.target    = r_target;

    bta_eval #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_eval (
        .i_in  (ev_in),
        .o_res (ev_res)
    );

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_found     = r_found;
        n_pick      = r_pick;
        n_pick_size = r_pick_size;
        n_prev_free = r_prev_free;
        n_prev      = r_prev;
        n_prev_size = r_prev_size;
        n_nxt       = r_nxt;
        n_next_free = r_next_free;
        n_next_size = r_next_size;
        n_status    = r_status;
        n_off       = r_off;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = r_pos[AW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (i_cfg_we && (i_cfg_idx == REG_REGION_BYTES)) begin
                    n_state = ST_INIT;
                end else if (start) begin
                    n_state     = ST_RD;
                    n_pos       = '0;
                    n_found     = 1'b0;
                    n_prev_free = 1'b0;
                    n_next_free = 1'b0;
                end
            end
            ST_INIT: begin
                ram_we         = chain_end != '0;
                ram_wdata.free = 1'b1;
                ram_wdata.size = chain_end - HB;
                n_state        = ST_IDLE;
            end
            ST_RD: begin
                // zero-byte allocate and free below the header end at once
                if (((r_func == FUNC_ALLOC) && (r_req == '0))
                        || ((r_func == FUNC_FREE) && r_bad)
                        || (r_pos >= chain_end)) begin
                    n_state = ST_END;
                end else begin
                    ram_re  = 1'b1;
                    n_state = ST_EV;
                end
            end
            ST_EV: begin
                n_pos   = ev_res.next[PW-1:0];
                n_state = ST_RD;
                if (r_func == FUNC_ALLOC) begin
                    if (ev_res.take) begin
                        n_found     = 1'b1;
                        n_pick      = r_pos;
                        n_pick_size = ram_rdata.size;
                    end
                    if (ev_res.stop) begin
                        n_state = ST_END;
                    end
                end else if (ev_res.at_target) begin
                    n_pick      = r_pos;
                    n_pick_size = ram_rdata.size;
                    n_nxt       = ev_res.next[PW-1:0];
                    n_state     = ram_rdata.free ? ST_END : ST_NRD;
                end else if (ev_res.past_target) begin
                    n_state = ST_END;
                end else begin
                    n_prev      = r_pos;
                    n_prev_size = ram_rdata.size;
                    n_prev_free = ram_rdata.free;
                end
            end
            ST_NRD: begin
                ram_raddr = r_nxt[AW-1:0];
                if (r_nxt < chain_end) begin
                    ram_re  = 1'b1;
                    n_state = ST_NEV;
                end else begin
                    n_state = ST_FW;
                end
            end
            ST_NEV: begin
                n_next_free = ram_rdata.free;
                n_next_size = ram_rdata.size;
                n_state     = ST_FW;
            end
            ST_FW: begin
                ram_we         = 1'b1;
                ram_waddr      = r_prev_free ? r_prev[AW-1:0] : r_pick[AW-1:0];
                ram_wdata.free = 1'b1;
                ram_wdata.size = merge_size;
                n_status       = STAT_OK;
                n_off          = '0;
                n_state        = ST_OUT;
            end
            ST_END: begin
                n_off = '0;
                if (r_func == FUNC_FREE) begin
                    n_status = STAT_BADFREE;
                    n_state  = ST_OUT;
                end else if (r_found) begin
                    n_state = ST_AW1;
                end else begin
                    n_status = STAT_NOFIT;
                    n_state  = ST_OUT;
                end
            end
            ST_AW1: begin
                ram_we = 1'b1;
                if (split) begin
                    ram_waddr      = split_pos[AW-1:0];
                    ram_wdata.free = 1'b1;
                    ram_wdata.size = split_rem - HB;
                    n_state        = ST_AW2;
                end else begin
                    ram_waddr      = r_pick[AW-1:0];
                    ram_wdata.free = 1'b0;
                    ram_wdata.size = r_pick_size;
                    n_state        = ST_OUT;
                end
                n_status = STAT_OK;
                n_off    = 12'(r_pick + HB);
            end
            ST_AW2: begin
                ram_we         = 1'b1;
                ram_waddr      = r_pick[AW-1:0];
                ram_wdata.free = 1'b0;
                ram_wdata.size = r_req;
                n_state        = ST_OUT;
            end
            ST_OUT: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_method <= FIT_FIRST;
            r_region <= PW'(OFFSET_LIMIT);
        end else begin
            r_state <= n_state;
            if (i_cfg_we && (i_cfg_idx == REG_FIT_METHOD)) begin
                r_method <= i_cfg_wdata[1:0];
            end
            if (i_cfg_we && (i_cfg_idx == REG_REGION_BYTES)) begin
                r_region <= i_cfg_wdata;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && start) begin
            r_func   <= i_func;
            r_req    <= i_request_size;
            r_target <= PW'(i_free_offset) - HB;
            r_bad    <= PW'(i_free_offset) < HB;
        end
        r_pos       <= n_pos;
        r_found     <= n_found;
        r_pick      <= n_pick;
        r_pick_size <= n_pick_size;
        r_prev_free <= n_prev_free;
        r_prev      <= n_prev;
        r_prev_size <= n_prev_size;
        r_nxt       <= n_nxt;
        r_next_free <= n_next_free;
        r_next_size <= n_next_size;
        r_status    <= n_status;
        r_off       <= n_off;
    end

    assign busy          = r_state != ST_IDLE;
    assign o_done        = r_state == ST_OUT;
    assign o_status      = r_status;
    assign o_data_offset = r_off;

    // a failed transaction never reports an offset
    `BTA_ASSERT_NOW(a_fail_no_off, o_done && (o_status != STAT_OK), o_data_offset == '0, "offset on failure")
    // an accepted request makes the block busy
    `BTA_ASSERT_NEXT(a_start_busy, start && !busy, busy, "request not taken")
    // result strobe lasts one cycle and returns to idle
    `BTA_ASSERT_NEXT(a_done_idle, o_done, !busy && !o_done, "result not single-cycle")
    // successful allocation lies past the first header
    `BTA_ASSERT_NOW(a_alloc_off, o_done && (o_status == STAT_OK) && (r_func == FUNC_ALLOC), o_data_offset >= 12'(HEADER_BYTES), "offset inside header")
endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for boundary_tag_fit_allocator.
// Depends on bta_pkg and the allocator RTL; holds its own block-chain predictor.

import bta_pkg::*;

class alloc_scoreboard;
    localparam int HB = DEF_HEADER_BYTES;

    // predicted header chain: data size, free mark, block-start mark per offset
    int unsigned blk_size[OFFSET_LIMIT];
    bit          blk_free[OFFSET_LIMIT];
    bit          blk_start[OFFSET_LIMIT];
    int unsigned chain_end;
    logic [1:0]  fit_method;
    logic [1:0]  exp_status[$];
    logic [11:0] exp_offset[$];
    int unsigned errors;
    int unsigned live_offsets[$];   // data offsets currently allocated

    function new();
        errors     = 0;
        fit_method = FIT_FIRST;
        rebuild_region(DEF_REGION_BYTES);
    endfunction

    function void rebuild_region(int unsigned region);
        int unsigned eff;
        eff = region;
        if (eff > DEF_REGION_BYTES) eff = DEF_REGION_BYTES;
        if (eff > OFFSET_LIMIT) eff = OFFSET_LIMIT;
        foreach (blk_size[i]) begin
            blk_size[i]  = 0;
            blk_free[i]  = 0;
            blk_start[i] = 0;
        end
        live_offsets.delete();
        if (eff < HB) begin
            chain_end = 0;
            return;
        end
        chain_end    = eff;
        blk_size[0]  = eff - HB;
        blk_free[0]  = 1;
        blk_start[0] = 1;
    endfunction

    function void set_config(logic [1:0] idx, logic [12:0] val);
        if (idx == REG_FIT_METHOD) fit_method = val[1:0];
        else if (idx == REG_REGION_BYTES) rebuild_region(val);
    endfunction

    function void coalesce();
        int unsigned pos, nxt;
        pos = 0;
        while (pos < chain_end) begin
            nxt = pos + HB + blk_size[pos];
            if (blk_free[pos]) begin
                while (nxt < chain_end && blk_free[nxt]) begin
                    blk_size[pos] += HB + blk_size[nxt];
                    blk_size[nxt]  = 0;
                    blk_free[nxt]  = 0;
                    blk_start[nxt] = 0;
                    nxt = pos + HB + blk_size[pos];
                end
            end
            pos = nxt;
        end
    endfunction

    // note one accepted request transaction and queue its expected result
    function void note_request(logic func, logic [12:0] req, logic [11:0] fo);
        int unsigned pos, pick, sz, b;
        bit          found;
        logic [1:0]  st;
        logic [11:0] off;
        st  = STAT_OK;
        off = 0;
        if (func == FUNC_ALLOC) begin
            found = 0;
            pick  = 0;
            pos   = 0;
            if (req != 0) begin
                while (pos < chain_end) begin
                    sz = blk_size[pos];
                    if (blk_free[pos] && sz >= req) begin
                        if (!found) begin
                            pick  = pos;
                            found = 1;
                        end else if (fit_method == FIT_BEST && sz < blk_size[pick]) begin
                            pick = pos;
                        end else if (fit_method == FIT_WORST && sz >= blk_size[pick]) begin
                            pick = pos;
                        end
                        if (fit_method != FIT_BEST && fit_method != FIT_WORST) break;
                    end
                    pos = pos + HB + blk_size[pos];
                end
            end
            if (!found) begin
                st = STAT_NOFIT;
            end else begin
                sz = blk_size[pick];
                if (sz - req > HB) begin
                    blk_size[pick + HB + req]  = sz - req - HB;
                    blk_free[pick + HB + req]  = 1;
                    blk_start[pick + HB + req] = 1;
                    blk_size[pick] = req;
                end
                blk_free[pick] = 0;
                off = 12'(pick + HB);
                live_offsets.push_back(pick + HB);
            end
        end else begin
            if (fo < HB || fo - HB >= chain_end) begin
                st = STAT_BADFREE;
            end else begin
                b = fo - HB;
                if (!blk_start[b] || blk_free[b]) begin
                    st = STAT_BADFREE;
                end else begin
                    blk_free[b] = 1;
                    coalesce();
                    foreach (live_offsets[i])
                        if (live_offsets[i] == fo) begin
                            live_offsets.delete(i);
                            break;
                        end
                end
            end
        end
        exp_status.push_back(st);
        exp_offset.push_back(off);
    endfunction

    function void check_result(logic [1:0] st, logic [11:0] off);
        logic [1:0]  es;
        logic [11:0] eo;
        if (exp_status.size() == 0) begin
            $display("%0t: unexpected result status=%0d offset=%0d", $time, st, off);
            errors++;
            return;
        end
        es = exp_status.pop_front();
        eo = exp_offset.pop_front();
        if (st !== es) begin
            $display("%0t: status expected %0d actual %0d", $time, es, st);
            errors++;
        end
        if (off !== eo) begin
            $display("%0t: data_offset expected %0d actual %0d", $time, eo, off);
            errors++;
        end
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_func;
    logic [12:0] i_request_size;
    logic [11:0] i_free_offset;
    logic        o_done;
    logic [1:0]  o_status;
    logic [11:0] o_data_offset;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [12:0] i_cfg_wdata;

    alloc_scoreboard sb;
    int unsigned     burst_left;   // requests left in the current sender burst

    boundary_tag_fit_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_request_size (i_request_size),
        .i_free_offset  (i_free_offset),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_data_offset  (o_data_offset),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Results cannot be held off, so every o_done cycle is one transaction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_status, o_data_offset);
    end

    // Generous ceiling: an unfinished run is stopped and reported as failing.
    initial begin
        #(12ns * 3000000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // One request transaction: held until accepted (start high, busy low).
    // Burst gaps land between transactions so idle falls on every phase.
    // The block stays busy after taking a request until its result strobe, so the
    // closing edge costs no throughput and keeps start to one update per edge.
    task automatic send_request(logic func, logic [12:0] req, logic [11:0] fo);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
        burst_left--;
        start          <= 1'b1;
        i_func         <= func;
        i_request_size <= req;
        i_free_offset  <= fo;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_request(func, req, fo);
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drain outstanding results, then allow the walk latency to settle.
    task automatic wait_idle();
        while (sb.exp_status.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] val);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.set_config(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random free: mostly live offsets, sometimes a random offset as noise.
    task automatic random_free();
        logic [11:0] fo;
        if (sb.live_offsets.size() != 0 && $urandom_range(0, 9) < 8)
            fo = 12'(sb.live_offsets[$urandom_range(0, sb.live_offsets.size() - 1)]);
        else
            fo = 12'($urandom);
        send_request(FUNC_FREE, 13'($urandom), fo);
    endtask

    task automatic random_alloc();
        logic [12:0] req;
        case ($urandom_range(0, 9))
            0:       req = 13'($urandom);
            1:       req = 13'($urandom_range(0, 4));
            default: req = 13'($urandom_range(1, 300));
        endcase
        send_request(FUNC_ALLOC, req, 12'($urandom));
    endtask

    initial begin
        logic [12:0] regions[6];
        int unsigned n;
        sb             = new();
        burst_left     = 0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_func         = FUNC_ALLOC;
        i_request_size = '0;
        i_free_offset  = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = REG_FIT_METHOD;
        i_cfg_wdata    = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero request, whole region, small remainder, bad frees,
        // merging, double free and an offset near the region end.
        send_request(FUNC_ALLOC, 13'd0, 12'd0);
        send_request(FUNC_ALLOC, 13'd8191, 12'd4095);
        send_request(FUNC_ALLOC, 13'd4096, 12'd0);
        send_request(FUNC_ALLOC, 13'd4080, 12'd0);      // whole region
        send_request(FUNC_FREE, 13'd0, 12'd16);
        send_request(FUNC_ALLOC, 13'd4070, 12'd0);      // remainder too small to split
        send_request(FUNC_FREE, 13'd0, 12'd16);
        send_request(FUNC_ALLOC, 13'd100, 12'd0);
        send_request(FUNC_ALLOC, 13'd200, 12'd0);
        send_request(FUNC_ALLOC, 13'd50, 12'd0);
        send_request(FUNC_FREE, 13'd0, 12'd0);          // below header
        send_request(FUNC_FREE, 13'd0, 12'd17);         // not a block start
        send_request(FUNC_FREE, 13'd0, 12'd4095);
        send_request(FUNC_FREE, 13'd0, 12'd132);        // middle block
        send_request(FUNC_FREE, 13'd0, 12'd132);        // already free
        send_request(FUNC_FREE, 13'd0, 12'd16);         // merges with the middle
        send_request(FUNC_FREE, 13'd0, 12'd348);

        // Phases across all methods (three acts as first fit) and region sizes.
        regions = '{13'd32, 13'd4096, 13'd8191, 13'd500, 13'd15, 13'd1000};
        for (int ph = 0; ph < 12; ph++) begin
            write_reg(REG_FIT_METHOD, 13'(ph % 4) | 13'($urandom_range(0, 2047) << 2));
            write_reg(REG_REGION_BYTES, regions[ph % 6]);
            if (ph == 5) write_reg(2'd3, 13'($urandom));     // unused index, ignored
            n = (ph == 4) ? 20 : 115;
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 99) < 55) random_alloc();
                else random_free();
            end
        end

        wait_idle();
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
